// ----- sv/color_string_parser_core_defines.svh -----
// Assertion macros shared by the color string parser verification files.
// Depends on nothing; the including scope must provide aclk and aresetn.
`ifndef COLOR_STRING_PARSER_CORE_DEFINES_SVH
`define COLOR_STRING_PARSER_CORE_DEFINES_SVH

// Checked only while the block is out of reset.
`define CSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, including those during reset.
`define CSP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- sv/csp_pkg.sv -----
// Types and constants of the color string parser.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package csp_pkg;

    localparam int CODE_W = 16;
    localparam int COLOR_W = 32;
    localparam int FORM_W = 2;
    localparam int HEX_DIGITS = 8;
    localparam int COMPONENTS = 4;

    localparam logic [CODE_W-1:0] SEP_RESET = 16'd44;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic [CODE_W-1:0] CH_HASH = 16'h0023;
    localparam logic [CODE_W-1:0] CH_ZERO = 16'h0030;
    localparam logic [CODE_W-1:0] CH_NINE = 16'h0039;
    localparam logic [CODE_W-1:0] CH_X = 16'h0078;
    localparam logic [CODE_W-1:0] CH_PLUS = 16'h002B;
    localparam logic [CODE_W-1:0] CH_MINUS = 16'h002D;
    localparam logic [CODE_W-1:0] CH_SPACE = 16'h0020;
    localparam logic [CODE_W-1:0] CH_TAB = 16'h0009;
    localparam logic [CODE_W-1:0] CH_CR = 16'h000D;
    localparam logic [CODE_W-1:0] CH_LC_A = 16'h0061;
    localparam logic [CODE_W-1:0] CH_LC_F = 16'h0066;
    localparam logic [CODE_W-1:0] CH_UC_A = 16'h0041;
    localparam logic [CODE_W-1:0] CH_UC_F = 16'h0046;

    localparam logic [3:0] HEX_LEN_MAX = 4'd9;
    localparam logic [2:0] FIELD_MAX = 3'd7;

    typedef enum logic [1:0] {
        MODE_UNDECIDED = 2'd0,
        MODE_HEX       = 2'd1,
        MODE_DEC       = 2'd2,
        MODE_ZERO      = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [FORM_W-1:0] {
        FORM_HEX    = 2'd0,
        FORM_DEC    = 2'd1,
        FORM_REJECT = 2'd2
    } form_t;

    typedef struct packed {
        logic       is_nul;
        logic       is_hash;
        logic       is_zero;
        logic       is_x;
        logic       is_sep;
        logic       is_space;
        logic       is_sign;
        logic       is_minus;
        logic       is_digit;
        logic [3:0] nibble;
    } class_t;

    typedef struct packed {
        mode_t                            mode;
        logic [3:0]                       hex_length;
        logic [HEX_DIGITS-1:0][3:0]       hex_digits;
        logic [2:0]                       field_total;
        logic [7:0]                       close_value;
        logic [COMPONENTS-1:0][7:0]       comp_bytes;
    } snapshot_t;

endpackage

// ----- sv/csp_char_class.sv -----
// Classifies one code unit for the color string parser.
// Depends on csp_pkg.
`timescale 1ns / 1ps

module csp_char_class (
    input  logic [csp_pkg::CODE_W-1:0] code,
    input  logic [csp_pkg::CODE_W-1:0] separator,
    output csp_pkg::class_t            cls
);

    logic is_lower;
    logic is_upper;

    assign is_lower = (code >= csp_pkg::CH_LC_A) && (code <= csp_pkg::CH_LC_F);
    assign is_upper = (code >= csp_pkg::CH_UC_A) && (code <= csp_pkg::CH_UC_F);

    always_comb begin
        cls.is_nul   = (code == '0);
        cls.is_hash  = (code == csp_pkg::CH_HASH);
        cls.is_zero  = (code == csp_pkg::CH_ZERO);
        cls.is_x     = (code == csp_pkg::CH_X);
        cls.is_sep   = (code == separator);
        cls.is_space = (code == csp_pkg::CH_SPACE)
                    || ((code >= csp_pkg::CH_TAB) && (code <= csp_pkg::CH_CR));
        cls.is_sign  = (code == csp_pkg::CH_PLUS) || (code == csp_pkg::CH_MINUS);
        cls.is_minus = (code == csp_pkg::CH_MINUS);
        cls.is_digit = (code >= csp_pkg::CH_ZERO) && (code <= csp_pkg::CH_NINE);
        if (cls.is_digit) begin
            cls.nibble = code[3:0];
        end else if (is_lower || is_upper) begin
            cls.nibble = code[3:0] + 4'd9;
        end else begin
            cls.nibble = 4'd0;
        end
    end

endmodule

// ----- sv/csp_color_pack.sv -----
// Builds the packed color and form code from the parser state at end of string.
// Depends on csp_pkg.
`timescale 1ns / 1ps

module csp_color_pack (
    input  csp_pkg::snapshot_t          snap,
    output logic [csp_pkg::COLOR_W-1:0] color,
    output csp_pkg::form_t              form
);

    logic [csp_pkg::COMPONENTS-1:0][7:0] bytes;
    logic [2:0]                          last_idx;
    logic [csp_pkg::HEX_DIGITS-1:0][3:0] d;

    assign d = snap.hex_digits;
    assign last_idx = snap.field_total - 3'd1;

    always_comb begin
        bytes = snap.comp_bytes;
        if (last_idx < 3'(csp_pkg::COMPONENTS)) begin
            bytes[last_idx[1:0]] = snap.close_value;
        end
    end

    always_comb begin
        color = '0;
        form  = csp_pkg::FORM_REJECT;
        case (snap.mode)
            csp_pkg::MODE_HEX: begin
                form = csp_pkg::FORM_HEX;
                case (snap.hex_length)
                    4'd3: color = {csp_pkg::ALPHA_OPAQUE, d[2], d[2], d[1], d[1], d[0], d[0]};
                    4'd4: color = {d[0], d[0], d[3], d[3], d[2], d[2], d[1], d[1]};
                    4'd6: color = {csp_pkg::ALPHA_OPAQUE, d[4], d[5], d[2], d[3], d[0], d[1]};
                    4'd8: color = {d[0], d[1], d[6], d[7], d[4], d[5], d[2], d[3]};
                    default: form = csp_pkg::FORM_REJECT;
                endcase
            end
            csp_pkg::MODE_DEC, csp_pkg::MODE_ZERO: begin
                case (snap.field_total)
                    3'd3: begin
                        color = {csp_pkg::ALPHA_OPAQUE, bytes[2], bytes[1], bytes[0]};
                        form  = csp_pkg::FORM_DEC;
                    end
                    3'd4: begin
                        color = {bytes[3], bytes[2], bytes[1], bytes[0]};
                        form  = csp_pkg::FORM_DEC;
                    end
                    default: form = csp_pkg::FORM_REJECT;
                endcase
            end
            default: form = csp_pkg::FORM_REJECT;
        endcase
    end

endmodule

// ----- sv/csp_parse_state.sv -----
// Parser state registers and their per-character update.
// Depends on csp_pkg.
`timescale 1ns / 1ps

module csp_parse_state (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  csp_pkg::class_t    cls,
    output csp_pkg::snapshot_t snap
);

    csp_pkg::mode_t  mode_reg, mode_next;
    logic [3:0]      hex_length_reg, hex_length_next;
    logic [2:0]      field_total_reg, field_total_next;
    csp_pkg::phase_t phase_reg, phase_next;
    logic            negative_reg, negative_next;
    logic [7:0]      value_reg, value_next;
    logic [csp_pkg::HEX_DIGITS-1:0][3:0] hex_digits_reg;
    logic [csp_pkg::COMPONENTS-1:0][7:0] comp_reg;

    logic       do_dec;
    logic       do_hex;
    logic       hex_restart;
    logic [7:0] close_value;
    logic [2:0] comp_idx;
    logic       comp_wr;
    logic       hex_wr;

    assign close_value = negative_reg ? (8'd0 - value_reg) : value_reg;
    assign comp_idx = field_total_reg - 3'd1;

    always_comb begin
        mode_next = mode_reg;
        if (step) begin
            if (cls.is_nul) begin
                mode_next = csp_pkg::MODE_UNDECIDED;
            end else begin
                case (mode_reg)
                    csp_pkg::MODE_UNDECIDED: begin
                        if (cls.is_hash) begin
                            mode_next = csp_pkg::MODE_HEX;
                        end else if (cls.is_zero) begin
                            mode_next = csp_pkg::MODE_ZERO;
                        end else begin
                            mode_next = csp_pkg::MODE_DEC;
                        end
                    end
                    csp_pkg::MODE_ZERO: begin
                        mode_next = cls.is_x ? csp_pkg::MODE_HEX : csp_pkg::MODE_DEC;
                    end
                    default: mode_next = mode_reg;
                endcase
            end
        end
    end

    always_comb begin
        do_dec      = 1'b0;
        do_hex      = 1'b0;
        hex_restart = 1'b0;
        if (step && !cls.is_nul) begin
            case (mode_reg)
                csp_pkg::MODE_UNDECIDED: do_dec = !cls.is_hash;
                csp_pkg::MODE_ZERO: begin
                    hex_restart = cls.is_x;
                    do_dec      = !cls.is_x;
                end
                csp_pkg::MODE_HEX: do_hex = 1'b1;
                default: do_dec = 1'b1;
            endcase
        end
    end

    always_comb begin
        hex_length_next  = hex_length_reg;
        field_total_next = field_total_reg;
        phase_next       = phase_reg;
        negative_next    = negative_reg;
        value_next       = value_reg;
        comp_wr          = 1'b0;
        hex_wr           = 1'b0;
        if (step && cls.is_nul) begin
            hex_length_next  = '0;
            field_total_next = 3'd1;
            phase_next       = csp_pkg::PH_SKIP;
            negative_next    = 1'b0;
            value_next       = '0;
        end else if (hex_restart) begin
            hex_length_next = '0;
        end else if (do_hex) begin
            hex_wr = !hex_length_reg[3];
            if (hex_length_reg < csp_pkg::HEX_LEN_MAX) begin
                hex_length_next = hex_length_reg + 4'd1;
            end
        end else if (do_dec) begin
            if (cls.is_sep) begin
                comp_wr       = (comp_idx < 3'(csp_pkg::COMPONENTS));
                phase_next    = csp_pkg::PH_SKIP;
                negative_next = 1'b0;
                value_next    = '0;
                if (field_total_reg < csp_pkg::FIELD_MAX) begin
                    field_total_next = field_total_reg + 3'd1;
                end
            end else if ((phase_reg == csp_pkg::PH_SKIP) && cls.is_space) begin
                phase_next = phase_reg;
            end else if ((phase_reg == csp_pkg::PH_SKIP) && cls.is_sign) begin
                negative_next = cls.is_minus;
                phase_next    = csp_pkg::PH_SIGN;
            end else if (phase_reg == csp_pkg::PH_DONE) begin
                phase_next = phase_reg;
            end else if (cls.is_digit) begin
                value_next = {value_reg[4:0], 3'b000} + {value_reg[6:0], 1'b0}
                           + {4'd0, cls.nibble};
                phase_next = csp_pkg::PH_DIGITS;
            end else begin
                phase_next = csp_pkg::PH_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= csp_pkg::MODE_UNDECIDED;
            hex_length_reg  <= '0;
            field_total_reg <= 3'd1;
            phase_reg       <= csp_pkg::PH_SKIP;
            negative_reg    <= 1'b0;
            value_reg       <= '0;
        end else begin
            mode_reg        <= mode_next;
            hex_length_reg  <= hex_length_next;
            field_total_reg <= field_total_next;
            phase_reg       <= phase_next;
            negative_reg    <= negative_next;
            value_reg       <= value_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hex_wr) begin
            hex_digits_reg[hex_length_reg[2:0]] <= cls.nibble;
        end
        if (comp_wr) begin
            comp_reg[comp_idx[1:0]] <= close_value;
        end
    end

    always_comb begin
        snap.mode        = mode_reg;
        snap.hex_length  = hex_length_reg;
        snap.hex_digits  = hex_digits_reg;
        snap.field_total = field_total_reg;
        snap.close_value = close_value;
        snap.comp_bytes  = comp_reg;
    end

endmodule

// ----- sv/color_string_parser_core.sv -----
// Top level of the color string parser: input register, parser state and result register.
// Depends on csp_pkg, csp_char_class, csp_parse_state and csp_color_pack.
`timescale 1ns / 1ps

// The block takes one code unit of a color string per transfer on the s_ channel and
// gives one result on the m_ channel for each terminating zero code unit. A string that
// starts with '#' or "0x" is read as 3, 4, 6 or 8 hex digits; any other string is read
// as three or four decimal fields split at the separator register, which resets to ','.
// The result carries the color as 0xAABBGGRR in m_tdata and the form code in m_tuser.
// The block takes one code unit every cycle unless stalled. A code unit is held in the
// input register, and for a zero code unit the result is loaded into the result register
// as the zero leaves the input register; the result register drives m_tvalid. While a
// result waits on m_tready, a following zero code unit stalls the input; other code units
// keep flowing. Write the separator only while no string is in progress.
module color_string_parser_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: [15:0] code_unit
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [csp_pkg::CODE_W-1:0]    s_tdata,
    // m_tdata: [31:0] color
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [csp_pkg::COLOR_W-1:0]   m_tdata,
    // m_tuser: [1:0] form
    output logic [csp_pkg::FORM_W-1:0]    m_tuser,
    // cfg_data: [15:0] separator
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [csp_pkg::CODE_W-1:0]    cfg_data
);

    logic                        in_valid_reg, in_valid_next;
    logic [csp_pkg::CODE_W-1:0]  in_code_reg;
    logic [csp_pkg::CODE_W-1:0]  sep_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [csp_pkg::COLOR_W-1:0] out_color_reg;
    csp_pkg::form_t              out_form_reg;

    csp_pkg::class_t    cls;
    csp_pkg::snapshot_t snap;
    logic [csp_pkg::COLOR_W-1:0] color;
    csp_pkg::form_t     form;
    logic               advance;
    logic               step;
    logic               emit;

    assign advance   = !in_valid_reg || !cls.is_nul || !out_valid_reg || m_tready;
    assign step      = in_valid_reg && advance;
    assign emit      = step && cls.is_nul;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = (s_tvalid && s_tready) ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    csp_char_class u_char_class (
        .code      (in_code_reg),
        .separator (sep_reg),
        .cls       (cls)
    );

    csp_parse_state u_parse_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cls     (cls),
        .snap    (snap)
    );

    csp_color_pack u_color_pack (
        .snap  (snap),
        .color (color),
        .form  (form)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sep_reg       <= csp_pkg::SEP_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                sep_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_code_reg <= s_tdata;
        end
        if (emit) begin
            out_color_reg <= color;
            out_form_reg  <= form;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_color_reg;
    assign m_tuser  = out_form_reg;

endmodule

// ----- sv/csp_checker.sv -----
// Port-level checks for the color string parser, bound to the top level.
// Depends on csp_pkg, color_string_parser_core_defines.svh and color_string_parser_core.
`timescale 1ns / 1ps
`include "color_string_parser_core_defines.svh"

module csp_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [csp_pkg::COLOR_W-1:0] m_tdata,
    input logic [csp_pkg::FORM_W-1:0]  m_tuser
);

    `CSP_ASSERT_ALWAYS(a_no_result_after_reset, !aresetn |=> !m_tvalid, "result right after reset")
    `CSP_ASSERT(a_result_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `CSP_ASSERT(a_reject_is_zero, m_tvalid && (m_tuser == csp_pkg::FORM_REJECT) |-> (m_tdata == '0), "rejected string with nonzero color")
    `CSP_ASSERT(a_form_known, m_tvalid |-> (m_tuser == csp_pkg::FORM_HEX) || (m_tuser == csp_pkg::FORM_DEC) || (m_tuser == csp_pkg::FORM_REJECT), "undefined form code")

endmodule

bind color_string_parser_core csp_checker u_csp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for color_string_parser_core: streams color strings in,
// predicts each packed color and form code, and checks every result transfer.
// Depends on csp_pkg and the color_string_parser_core RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int LONG_HOLD = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [csp_pkg::COLOR_W-1:0] color;
        csp_pkg::form_t              form;
    } color_result_t;

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [csp_pkg::CODE_W-1:0]   s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [csp_pkg::COLOR_W-1:0]  m_tdata;
    logic [csp_pkg::FORM_W-1:0]   m_tuser;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [csp_pkg::CODE_W-1:0]   cfg_data;

    color_result_t pending_colors[$];
    int  errors = 0;
    int  units_sent = 0;
    bit  idle_en = 1'b0;
    int  hold_requests = 0;

    // Predictor state.
    logic [csp_pkg::CODE_W-1:0] sep_q;
    logic [1:0]                 pos_q;
    csp_pkg::mode_t             mode_q;
    logic [3:0]                 hexlen_q;
    logic [3:0]                 hexdig_q [csp_pkg::HEX_DIGITS];
    logic [2:0]                 fields_q;
    csp_pkg::phase_t            phase_q;
    bit                         neg_q;
    logic [7:0]                 fval_q;
    logic [7:0]                 comp_q [csp_pkg::COMPONENTS];

    color_string_parser_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void clear_parse_state();
        pos_q = 2'd0;
        mode_q = csp_pkg::MODE_UNDECIDED;
        hexlen_q = 4'd0;
        hexdig_q = '{default: 4'd0};
        fields_q = 3'd1;
        phase_q = csp_pkg::PH_SKIP;
        neg_q = 1'b0;
        fval_q = 8'd0;
        comp_q = '{default: 8'd0};
    endfunction

    function automatic logic [3:0] nibble_value(logic [csp_pkg::CODE_W-1:0] c);
        if (c >= csp_pkg::CH_ZERO && c <= csp_pkg::CH_NINE) return 4'(c - csp_pkg::CH_ZERO);
        if (c >= csp_pkg::CH_LC_A && c <= csp_pkg::CH_LC_F)
            return 4'(c - csp_pkg::CH_LC_A + 10);
        if (c >= csp_pkg::CH_UC_A && c <= csp_pkg::CH_UC_F)
            return 4'(c - csp_pkg::CH_UC_A + 10);
        return 4'd0;
    endfunction

    function automatic bit is_white(logic [csp_pkg::CODE_W-1:0] c);
        return (c == csp_pkg::CH_SPACE) || (c >= csp_pkg::CH_TAB && c <= csp_pkg::CH_CR);
    endfunction

    function automatic void close_field_pred();
        logic [7:0] v;
        logic [2:0] idx;
        v = neg_q ? (8'd0 - fval_q) : fval_q;
        idx = fields_q - 3'd1;
        if (idx < csp_pkg::COMPONENTS) comp_q[idx[1:0]] = v;
        phase_q = csp_pkg::PH_SKIP;
        neg_q = 1'b0;
        fval_q = 8'd0;
    endfunction

    function automatic void decimal_unit(logic [csp_pkg::CODE_W-1:0] c);
        int unsigned acc;
        if (c == sep_q) begin
            close_field_pred();
            if (fields_q < csp_pkg::FIELD_MAX) fields_q = fields_q + 3'd1;
            return;
        end
        if (phase_q == csp_pkg::PH_SKIP) begin
            if (is_white(c)) return;
            if (c == csp_pkg::CH_PLUS || c == csp_pkg::CH_MINUS) begin
                neg_q = (c == csp_pkg::CH_MINUS);
                phase_q = csp_pkg::PH_SIGN;
                return;
            end
        end
        if (phase_q == csp_pkg::PH_DONE) return;
        if (c >= csp_pkg::CH_ZERO && c <= csp_pkg::CH_NINE) begin
            acc = fval_q * 10 + (c - csp_pkg::CH_ZERO);
            fval_q = acc[7:0];
            phase_q = csp_pkg::PH_DIGITS;
        end else begin
            phase_q = csp_pkg::PH_DONE;
        end
    endfunction

    function automatic logic [7:0] doubled(logic [3:0] n);
        return {n, n};
    endfunction

    function automatic logic [7:0] digit_pair(int i);
        return {hexdig_q[3'(i)], hexdig_q[3'(i + 1)]};
    endfunction

    function automatic logic [31:0] pack_color(logic [7:0] a, logic [7:0] r,
                                               logic [7:0] g, logic [7:0] b);
        return {a, b, g, r};
    endfunction

    // Returns 1 when the code unit ends a string and a color result is due.
    function automatic bit predict_color(input logic [csp_pkg::CODE_W-1:0] c,
                                         output logic [csp_pkg::COLOR_W-1:0] color,
                                         output csp_pkg::form_t form);
        color = '0;
        form = csp_pkg::FORM_REJECT;
        if (c != '0) begin
            case (mode_q)
                csp_pkg::MODE_UNDECIDED: begin
                    if (c == csp_pkg::CH_HASH) begin
                        mode_q = csp_pkg::MODE_HEX;
                    end else begin
                        mode_q = (c == csp_pkg::CH_ZERO) ? csp_pkg::MODE_ZERO
                                                         : csp_pkg::MODE_DEC;
                        decimal_unit(c);
                    end
                end
                csp_pkg::MODE_ZERO: begin
                    if (c == csp_pkg::CH_X) begin
                        mode_q = csp_pkg::MODE_HEX;
                        hexlen_q = 4'd0;
                    end else begin
                        mode_q = csp_pkg::MODE_DEC;
                        decimal_unit(c);
                    end
                end
                csp_pkg::MODE_HEX: begin
                    if (hexlen_q < 4'd8) hexdig_q[hexlen_q[2:0]] = nibble_value(c);
                    if (hexlen_q < csp_pkg::HEX_LEN_MAX) hexlen_q = hexlen_q + 4'd1;
                end
                default: decimal_unit(c);
            endcase
            if (pos_q < 2'd3) pos_q = pos_q + 2'd1;
            return 1'b0;
        end
        if (mode_q == csp_pkg::MODE_HEX) begin
            form = csp_pkg::FORM_HEX;
            case (hexlen_q)
                4'd3: color = pack_color(csp_pkg::ALPHA_OPAQUE, doubled(hexdig_q[0]),
                                         doubled(hexdig_q[1]), doubled(hexdig_q[2]));
                4'd4: color = pack_color(doubled(hexdig_q[0]), doubled(hexdig_q[1]),
                                         doubled(hexdig_q[2]), doubled(hexdig_q[3]));
                4'd6: color = pack_color(csp_pkg::ALPHA_OPAQUE, digit_pair(0), digit_pair(2),
                                         digit_pair(4));
                4'd8: color = pack_color(digit_pair(0), digit_pair(2), digit_pair(4),
                                         digit_pair(6));
                default: form = csp_pkg::FORM_REJECT;
            endcase
        end else if (mode_q != csp_pkg::MODE_UNDECIDED) begin
            close_field_pred();
            if (fields_q == 3'd3) begin
                color = pack_color(csp_pkg::ALPHA_OPAQUE, comp_q[0], comp_q[1], comp_q[2]);
                form = csp_pkg::FORM_DEC;
            end else if (fields_q == 3'd4) begin
                color = pack_color(comp_q[3], comp_q[0], comp_q[1], comp_q[2]);
                form = csp_pkg::FORM_DEC;
            end
        end
        clear_parse_state();
        return 1'b1;
    endfunction

    task automatic send_unit(input logic [csp_pkg::CODE_W-1:0] c);
        int gap;
        logic [csp_pkg::COLOR_W-1:0] color;
        csp_pkg::form_t form;
        color_result_t res;
        @(negedge aclk);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        do @(posedge aclk); while (!s_tready);
        units_sent++;
        if (predict_color(c, color, form)) begin
            res.color = color;
            res.form = form;
            pending_colors.insert(pending_colors.size(), res);
        end
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) send_unit({8'h00, text[i]});
        send_unit('0);
    endtask

    task automatic wait_for_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge aclk);
    endtask

    task automatic write_separator(input logic [csp_pkg::CODE_W-1:0] value);
        wait_for_drain();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        sep_q = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [csp_pkg::CODE_W-1:0] random_hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return 16'(csp_pkg::CH_ZERO + r);
        if (r < 16) return 16'(csp_pkg::CH_LC_A + (r - 10));
        return 16'(csp_pkg::CH_UC_A + (r - 16));
    endfunction

    function automatic logic [csp_pkg::CODE_W-1:0] random_white();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? csp_pkg::CH_SPACE : 16'(csp_pkg::CH_TAB + r);
    endfunction

    task automatic send_random_string();
        int kind;
        int len;
        int nfields;
        int ndigits;
        logic [csp_pkg::CODE_W-1:0] split;
        kind = $urandom_range(0, 19);
        split = (sep_q == '0) ? 16'h002C : sep_q;
        if (kind < 9) begin
            if ($urandom_range(0, 1)) begin
                send_unit(csp_pkg::CH_HASH);
            end else begin
                send_unit(csp_pkg::CH_ZERO);
                send_unit(csp_pkg::CH_X);
            end
            case ($urandom_range(0, 9))
                0, 1: len = 3;
                2, 3: len = 4;
                4, 5: len = 6;
                6, 7: len = 8;
                default: len = $urandom_range(0, 10);
            endcase
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) == 0) send_unit(16'($urandom_range(1, 65535)));
                else send_unit(random_hex_char());
            end
        end else if (kind < 18) begin
            nfields = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8)
                                                  : $urandom_range(3, 4);
            for (int f = 0; f < nfields; f++) begin
                if (f != 0) send_unit(split);
                repeat ($urandom_range(0, 2)) send_unit(random_white());
                case ($urandom_range(0, 7))
                    0: send_unit(csp_pkg::CH_PLUS);
                    1: send_unit(csp_pkg::CH_MINUS);
                    default: ;
                endcase
                ndigits = $urandom_range(0, 4);
                for (int d = 0; d < ndigits; d++)
                    send_unit(16'(csp_pkg::CH_ZERO + $urandom_range(0, 9)));
                case ($urandom_range(0, 9))
                    0: send_unit(random_white());
                    1: send_unit(16'($urandom_range(1, 65535)));
                    2: send_unit(csp_pkg::CH_LC_A);
                    default: ;
                endcase
            end
        end else begin
            len = $urandom_range(0, 8);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 1)) send_unit(16'($urandom_range(1, 65535)));
                else send_unit(16'($urandom_range(1, 127)));
            end
        end
        send_unit('0);
    endtask

    task automatic test_hex_forms();
        send_text("#fA3");
        send_text("#1234");
        send_text("0xAbCdEf");
        send_text("#FFFFFFFF");
        send_text("#00000000");
        send_text("#12g");
        send_text("#12345");
        send_text("#123456789");
        send_text("#");
        send_unit(csp_pkg::CH_HASH);
        send_unit(16'hFFFF);
        send_unit(16'h8000);
        send_unit(16'h7FFF);
        send_unit('0);
    endtask

    task automatic test_decimal_forms();
        send_text("255,128,0");
        send_text(" \t+12, -1 ,  300,7");
        send_unit(csp_pkg::CH_CR);
        send_text("9,8,7");
        send_text("1,2");
        send_text("1,2,3,4,5,6,7,8,9");
        send_text("12a3,4,5");
        send_text("--5,4,3");
        send_unit(16'hFFFF);
        send_text("1,2,3");
    endtask

    task automatic test_special_cases();
        send_unit('0);
        send_text("0,0,0");
        send_text("0");
        send_text("0X12");
        send_text("0x");
    endtask

    task automatic test_separator_values();
        write_separator(csp_pkg::CH_HASH);
        send_text("#1,2,3");
        send_text("1#2#3");
        write_separator('0);
        send_text("1,2,3");
        write_separator(16'hFFFF);
        send_unit(16'(csp_pkg::CH_ZERO + 1));
        send_unit(16'hFFFF);
        send_unit(16'(csp_pkg::CH_ZERO + 2));
        send_unit(16'hFFFF);
        send_unit(16'(csp_pkg::CH_ZERO + 3));
        send_unit(16'hFFFF);
        send_text("4");
        write_separator(csp_pkg::SEP_RESET);
    endtask

    task automatic test_backpressure();
        idle_en = 1'b0;
        hold_requests++;
        repeat (15) send_text("#abc");
        wait_for_drain();
        idle_en = 1'b1;
    endtask

    task automatic test_random_strings();
        logic [csp_pkg::CODE_W-1:0] seps [6];
        int phase_end;
        seps = '{16'h002C, 16'h003B, 16'h0020, 16'hFFFF, 16'h0000, 16'h0030};
        for (int p = 0; p < 8; p++) begin
            if (p < 6) write_separator(seps[3'(p)]);
            else write_separator(16'($urandom_range(0, 65535)));
            idle_en = (p % 3 != 2);
            phase_end = units_sent + 120;
            while (units_sent < phase_end) send_random_string();
        end
        write_separator(csp_pkg::SEP_RESET);
        idle_en = 1'b0;
        phase_end = units_sent + 200;
        while (units_sent < phase_end) send_random_string();
    endtask

    // Result side: random stalls and one long hold-off per request.
    initial begin : result_ready
        int stall;
        int holds_served;
        stall = 0;
        holds_served = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_served != hold_requests) begin
                holds_served++;
                stall = LONG_HOLD;
            end else if (stall == 0 && idle_en && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 17);
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        color_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_colors.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual color %08h form %0d",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                exp_res = pending_colors.pop_front();
                if (m_tdata !== exp_res.color) begin
                    $display("%0t: color mismatch: expected %08h, actual %08h",
                             $time, exp_res.color, m_tdata);
                    errors++;
                end
                if (m_tuser !== exp_res.form) begin
                    $display("%0t: form mismatch: expected %0d, actual %0d",
                             $time, exp_res.form, m_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet = quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        sep_q = csp_pkg::SEP_RESET;
        clear_parse_state();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        idle_en = 1'b1;

        test_hex_forms();
        test_decimal_forms();
        test_special_cases();
        test_separator_values();
        test_backpressure();
        test_random_strings();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_colors.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_colors.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
